// ===== rtl/mlk_pkg.sv =====
// Shared types and constants of the mutation likelihood kernel.
package mlk_pkg;

    localparam int POSITIONS = 33;
    localparam int POS_W     = $clog2(POSITIONS);
    localparam int STEPS     = 2 * POSITIONS;
    localparam int STEP_W    = $clog2(STEPS + 1);
    localparam int MASK_W    = 33;
    localparam int ETA_W     = 16;
    localparam int ACC_W     = 33;
    localparam int FAC_W     = ETA_W + 1;
    localparam int PROD_W    = ACC_W + FAC_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 33;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ADE_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYT_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADE_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYT_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_ADE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_CYT    = 3'd5;

    typedef struct packed {
        logic [MASK_W-1:0] mut;
        logic [MASK_W-1:0] unp;
        logic [MASK_W-1:0] amask;
        logic [MASK_W-1:0] cmask;
        logic [ETA_W-1:0]  eta_a;
        logic [ETA_W-1:0]  eta_c;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } back_state_t;

endpackage

// ===== rtl/mutation_likelihood_kernel_top.sv =====
// Top level of the mutation likelihood kernel.
// Each item pairs a mutation pattern with a structure and yields one Q1.32
// likelihood (2^32 is 1.0). The back part applies one position factor per
// cycle, adenine positions then cytosine positions: it loads an item from the
// queue while idle, walks every position in its run state, and then shows the
// result until it is taken. It takes no new item before its result is taken,
// so a stalled output holds it up. A two-item queue lets the input take new
// items while a result waits. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module mutation_likelihood_kernel_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlk_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mlk_pkg::IN_DATA_W-1:0]   s_tdata,  // mutation_pattern, fold_unpaired
    input  logic                            s_tuser,  // allele_select
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mlk_pkg::OUT_DATA_W-1:0]  m_tdata   // likelihood
);

    mlk_pkg::item_t   wr_item;
    mlk_pkg::item_t   rd_item;
    logic             push;
    logic             fifo_full;
    logic             rd_valid;
    logic             pop;

    mlk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .item      (wr_item)
    );

    mlk_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (wr_item),
        .full     (fifo_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_item  (rd_item)
    );

    mlk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_item  (rd_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/mlk_front.sv =====
// Front part: configuration registers, item intake and mask selection.
module mlk_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlk_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mlk_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            fifo_full,
    output logic                            push,
    output mlk_pkg::item_t                  item
);

    logic [mlk_pkg::MASK_W-1:0] ade_first_reg;
    logic [mlk_pkg::MASK_W-1:0] cyt_first_reg;
    logic [mlk_pkg::MASK_W-1:0] ade_second_reg;
    logic [mlk_pkg::MASK_W-1:0] cyt_second_reg;
    logic [mlk_pkg::ETA_W-1:0]  eta_a_reg;
    logic [mlk_pkg::ETA_W-1:0]  eta_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ade_first_reg  <= '0;
            cyt_first_reg  <= '0;
            ade_second_reg <= '0;
            cyt_second_reg <= '0;
            eta_a_reg      <= '0;
            eta_c_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mlk_pkg::REG_ADE_FIRST:  ade_first_reg  <= cfg_data[mlk_pkg::MASK_W-1:0];
                mlk_pkg::REG_CYT_FIRST:  cyt_first_reg  <= cfg_data[mlk_pkg::MASK_W-1:0];
                mlk_pkg::REG_ADE_SECOND: ade_second_reg <= cfg_data[mlk_pkg::MASK_W-1:0];
                mlk_pkg::REG_CYT_SECOND: cyt_second_reg <= cfg_data[mlk_pkg::MASK_W-1:0];
                mlk_pkg::REG_ETA_ADE:    eta_a_reg      <= cfg_data[mlk_pkg::ETA_W-1:0];
                mlk_pkg::REG_ETA_CYT:    eta_c_reg      <= cfg_data[mlk_pkg::ETA_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    always_comb
    begin
        item.mut   = s_tdata[mlk_pkg::MASK_W-1:0];
        item.unp   = s_tdata[2*mlk_pkg::MASK_W-1:mlk_pkg::MASK_W];
        item.amask = s_tuser ? ade_second_reg : ade_first_reg;
        item.cmask = s_tuser ? cyt_second_reg : cyt_first_reg;
        item.eta_a = eta_a_reg;
        item.eta_c = eta_c_reg;
    end

endmodule

// ===== rtl/mlk_fifo.sv =====
// Two-entry queue between the front and back parts.
module mlk_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mlk_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output logic           rd_valid,
    output mlk_pkg::item_t rd_item
);

    mlk_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ===== rtl/mlk_back.sv =====
// Back part: walks the positions and multiplies the likelihood, one factor per cycle.
module mlk_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_valid,
    input  mlk_pkg::item_t                 rd_item,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mlk_pkg::OUT_DATA_W-1:0] m_tdata
);

    mlk_pkg::back_state_t         state_reg, state_next;
    mlk_pkg::item_t               item_reg;
    logic [mlk_pkg::STEP_W-1:0]   step_reg;
    logic [mlk_pkg::ACC_W-1:0]    acc_reg;
    logic [mlk_pkg::ACC_W-1:0]    acc_step;
    logic                         cyt_phase;
    logic [mlk_pkg::POS_W-1:0]    pos;
    logic                         marked;
    logic [mlk_pkg::ETA_W-1:0]    eta;
    logic [mlk_pkg::FAC_W-1:0]    factor;
    logic [mlk_pkg::PROD_W-1:0]   prod;
    logic                         last_step;

    assign cyt_phase = (step_reg >= mlk_pkg::STEP_W'(mlk_pkg::POSITIONS));
    assign pos       = cyt_phase ? mlk_pkg::POS_W'(step_reg - mlk_pkg::STEP_W'(mlk_pkg::POSITIONS))
                                 : mlk_pkg::POS_W'(step_reg);
    assign marked    = cyt_phase ? item_reg.cmask[pos] : item_reg.amask[pos];
    assign eta       = cyt_phase ? item_reg.eta_c : item_reg.eta_a;
    assign factor    = item_reg.mut[pos] ? {1'b0, eta}
                                         : ({1'b1, {mlk_pkg::ETA_W{1'b0}}} - {1'b0, eta});
    assign prod      = {{mlk_pkg::FAC_W{1'b0}}, acc_reg} * {{mlk_pkg::ACC_W{1'b0}}, factor}
                       + mlk_pkg::PROD_W'(1 << (mlk_pkg::ETA_W - 1));
    assign last_step = (step_reg == mlk_pkg::STEP_W'(mlk_pkg::STEPS - 1));

    // Marked paired positions keep the value unless mutated, which forces zero.
    always_comb
    begin
        acc_step = acc_reg;
        if (marked)
        begin
            if (item_reg.unp[pos])
                acc_step = prod[mlk_pkg::ETA_W +: mlk_pkg::ACC_W];
            else if (item_reg.mut[pos])
                acc_step = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlk_pkg::BK_IDLE: if (rd_valid) state_next = mlk_pkg::BK_RUN;
            mlk_pkg::BK_RUN:  if (last_step) state_next = mlk_pkg::BK_DONE;
            mlk_pkg::BK_DONE: if (m_tready) state_next = mlk_pkg::BK_IDLE;
            default:          state_next = mlk_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            mlk_pkg::BK_IDLE: pop = rd_valid;
            mlk_pkg::BK_DONE: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_tdata = {{(mlk_pkg::OUT_DATA_W - mlk_pkg::ACC_W){1'b0}}, acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlk_pkg::BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                step_reg <= '0;
            else if (state_reg == mlk_pkg::BK_RUN)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= rd_item;
            acc_reg  <= {1'b1, {(mlk_pkg::ACC_W - 1){1'b0}}};
        end
        else if (state_reg == mlk_pkg::BK_RUN)
            acc_reg <= acc_step;
    end

endmodule

// ===== rtl/mlk_checker.sv =====
// Port-level checker for the mutation likelihood kernel and its bind.
module mlk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mlk_pkg::OUT_DATA_W-1:0]  m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[mlk_pkg::OUT_DATA_W-1:mlk_pkg::ACC_W] == '0)
                     && (!m_tdata[mlk_pkg::ACC_W-1] || (m_tdata[mlk_pkg::ACC_W-2:0] == '0)))
        else $error("likelihood above one");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("two results without a compute pass between them");

endmodule

bind mutation_likelihood_kernel_top mlk_checker u_mlk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
